// ----- rtl/core/ist_pkg.sv -----
package ist_pkg;

  // Table size and the widths that follow from it.
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned OUT_CNT_W = 5;

  // Command codes. Code 3 is unused and behaves as a query.
  localparam logic [1:0] CMD_QUERY  = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]                command;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                 was_present;
    logic                 add_refused;
    logic [OUT_CNT_W-1:0] element_count;
    logic                 set_empty;
  } out_item_t;

endpackage

// ----- rtl/core/ist_ram.sv -----
module ist_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // One write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/integer_set_table_core.sv -----
// Channel  Direction  Payload     Handshake
// in       input      in_item_t   in_valid_i / in_ready_o
// out      output     out_item_t  out_valid_o / out_ready_i
//
// After an item is accepted the block scans the held slots, reading one slot a cycle
// from the value RAM, up to the slot of the match or, when the value is absent, all of
// them; the scan is skipped for an empty table. An update step follows, then a move
// step for a removal of a held value, then the response step. The next item can be
// accepted in the same cycle that the result appears.
// Reset clears the held count and the control state; the RAM holds no reset value.
// An item may be accepted while the previous result waits; a stalled result holds
// the block in its response state until it is taken.
module integer_set_table_core import ist_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_MOVE   = 3'd3;
  localparam logic [2:0] ST_RESP   = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [ADDR_W-1:0]  idx_q, idx_d;
  logic [ADDR_W-1:0]  slot_q, slot_d;
  logic               present_q, present_d;
  logic               refused_q, refused_d;
  logic [1:0]         cmd_q, cmd_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_item_q, out_item_d;

  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [VALUE_W-1:0] rd_data;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic [CNT_W-1:0]   next_idx;
  logic [CNT_W-1:0]   last;
  logic               out_free;

  assign next_idx = CNT_W'(idx_q) + CNT_W'(1);
  assign last     = count_q - CNT_W'(1);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  // Storage for the held values, slots 0 to count-1.
  ist_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Sequencer: scan the packed slots, then read-modify-write the table.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    slot_d      = slot_q;
    present_d   = present_q;
    refused_d   = refused_q;
    cmd_d       = cmd_q;
    value_d     = value_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = value_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d     = in_item_i.command;
          value_d   = in_item_i.value;
          present_d = 1'b0;
          refused_d = 1'b0;
          idx_d     = '0;
          if (count_q == '0) begin
            state_d = ST_UPDATE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Read data belongs to slot idx_q, requested in the previous cycle.
        if (rd_data == value_q) begin
          present_d = 1'b1;
          slot_d    = idx_q;
          state_d   = ST_UPDATE;
        end else if (next_idx < count_q) begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(next_idx);
          idx_d   = ADDR_W'(next_idx);
        end else begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_d = ST_RESP;
        if (cmd_q == CMD_ADD && !present_q) begin
          if (count_q < CNT_W'(CAPACITY)) begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(count_q);
            wr_data = value_q;
            count_d = count_q + CNT_W'(1);
          end else begin
            refused_d = 1'b1;
          end
        end else if (cmd_q == CMD_REMOVE && present_q) begin
          // Fetch the last entry to fill the hole.
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(last);
          state_d = ST_MOVE;
        end
      end
      ST_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = slot_q;
        wr_data = rd_data;
        count_d = last;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d                = 1'b1;
          out_item_d.was_present     = present_q;
          out_item_d.add_refused     = refused_q;
          out_item_d.element_count   = OUT_CNT_W'(count_q);
          out_item_d.set_empty       = (count_q == '0);
          state_d                    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    slot_q     <= slot_d;
    present_q  <= present_d;
    refused_q  <= refused_d;
    cmd_q      <= cmd_d;
    value_q    <= value_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // The held count never passes the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("held count exceeds capacity");

  // The RAM is written only by the update and move steps.
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_UPDATE || state_q == ST_MOVE))
    else $error("RAM write outside update");

  // A refusal is only reported against a full table.
  a_refuse_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && refused_q) |-> count_q == CNT_W'(CAPACITY))
    else $error("add refused with room left");

  // A held value is never also refused.
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.was_present && out_item_o.add_refused))
    else $error("present and refused together");

  // An accepted item always leaves the idle state.
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q != ST_IDLE)
    else $error("accepted item not processed");

endmodule

// ----- tb/sv/integer_set_table_core_tb.sv -----
`timescale 1ns / 100ps

module integer_set_table_core_tb;
  import ist_pkg::*;

  // Code 3 has no operation of its own and behaves as a query.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];

  // Shadow copy of the table contents.
  logic [VALUE_W-1:0] shadow_vals [CAPACITY];
  int unsigned        shadow_count = 0;

  logic        item_taken = 1'b0;
  int unsigned items_loaded = 0;
  int unsigned results_seen = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  bit          pressure_done = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;

  integer_set_table_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always #1 clk = ~clk;

  // Apply one command to the shadow table and return the result it should produce.
  function automatic out_item_t apply_set_op(in_item_t it);
    out_item_t   res;
    int unsigned slot;
    bit          present;
    bit          refused;
    slot = shadow_count;
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (shadow_vals[i] == it.value && slot == shadow_count) begin
        slot = i;
      end
    end
    present = (slot < shadow_count);
    refused = 1'b0;
    if (it.command == CMD_ADD) begin
      if (!present) begin
        if (shadow_count < CAPACITY) begin
          shadow_vals[shadow_count] = it.value;
          shadow_count++;
        end else begin
          refused = 1'b1;
        end
      end
    end else if (it.command == CMD_REMOVE) begin
      if (present) begin
        // The last entry moves into the freed slot.
        shadow_vals[slot] = shadow_vals[shadow_count - 1];
        shadow_count--;
      end
    end
    res.was_present   = present;
    res.add_refused   = refused;
    res.element_count = OUT_CNT_W'(shadow_count);
    res.set_empty     = (shadow_count == 0);
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic queue_item(logic [1:0] cmd, logic [VALUE_W-1:0] val);
    in_item_t it;
    it.command = cmd;
    it.value   = val;
    pending_items.push_back(it);
  endtask

  // Idle length after an item: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Driver: a new item goes out at the falling edge once the previous one was taken.
  always @(negedge clk) begin : drive_items
    logic     nxt_valid;
    in_item_t nxt_item;
    nxt_valid = in_valid;
    nxt_item  = in_item;
    if (rst_n && (!in_valid || item_taken)) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() > 0) begin
        nxt_item  = pending_items.pop_front();
        nxt_valid = 1'b1;
        items_loaded++;
        // Every fourth stretch of 64 items runs back to back.
        gap_left = (((items_loaded / 64) % 4) == 3) ? 0 : pick_gap();
      end
    end
    in_valid <= nxt_valid;
    in_item  <= nxt_item;
  end

  // Receiver: random stalls, one long hold-off, and stretches without stalls.
  always @(negedge clk) begin : drive_ready
    int unsigned r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!pressure_done && results_seen >= 300) begin
      pressure_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (((results_seen / 64) % 4) == 2) begin
      out_ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_ready <= 1'b1;
      end else if (r < 96) begin
        out_ready <= 1'b0;
      end else begin
        hold_left = $urandom_range(10, 40);
        out_ready <= 1'b0;
      end
    end
  end

  // Monitor: results are checked against the oldest expectation first.
  always @(posedge clk) begin : watch_channels
    out_item_t want;
    item_taken <= in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, got present %0d refused %0d count %0d empty %0d",
                 $time, out_item.was_present, out_item.add_refused,
                 out_item.element_count, out_item.set_empty);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("was_present", 32'(want.was_present), 32'(out_item.was_present));
        check_field("add_refused", 32'(want.add_refused), 32'(out_item.add_refused));
        check_field("element_count", 32'(want.element_count),
                    32'(out_item.element_count));
        check_field("set_empty", 32'(want.set_empty), 32'(out_item.set_empty));
      end
    end
    if (rst_n && in_valid && in_ready) begin
      expected_results.push_back(apply_set_op(in_item));
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : run_test
    logic [VALUE_W-1:0] value_pool [POOL_SIZE];
    logic [1:0]         cmd;
    logic [VALUE_W-1:0] val;
    int unsigned        r;
    bit                 add_heavy;

    // Directed part: extremes, the unused code, duplicates, misses and a full table.
    queue_item(CMD_QUERY, 32'h0000_0000);
    queue_item(CMD_ADD, 32'h8000_0000);
    queue_item(CMD_ADD, 32'h7FFF_FFFF);
    queue_item(CMD_ADD, 32'h0000_0000);
    queue_item(CMD_ADD, 32'hFFFF_FFFF);
    queue_item(CMD_ADD, 32'h7FFF_FFFF);
    queue_item(CMD_UNUSED, 32'h7FFF_FFFF);
    queue_item(CMD_REMOVE, 32'd12345);
    queue_item(CMD_REMOVE, 32'h8000_0000);
    queue_item(CMD_QUERY, 32'hFFFF_FFFF);
    for (int i = 1; i <= 13; i++) begin
      queue_item(CMD_ADD, 32'(i));
    end
    queue_item(CMD_ADD, 32'd100);
    queue_item(CMD_ADD, 32'h7FFF_FFFF);
    queue_item(CMD_UNUSED, 32'd100);

    // Random part over a small pool, so hits, refusals and emptying all occur.
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) begin
      value_pool[i] = $urandom();
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Phases alternate between filling and draining the table.
      add_heavy = ((n / 120) % 2) == 0;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        cmd = CMD_UNUSED;
      end else if (r < 30) begin
        cmd = CMD_QUERY;
      end else if (r < (add_heavy ? 80 : 50)) begin
        cmd = CMD_ADD;
      end else begin
        cmd = CMD_REMOVE;
      end
      if ($urandom_range(0, 99) < 80) begin
        val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
        val = $urandom();
      end
      queue_item(cmd, val);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait until everything has been sent and answered, then let the block settle.
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/ist_pkg.sv
rtl/core/ist_ram.sv
rtl/core/integer_set_table_core.sv
tb/sv/integer_set_table_core_tb.sv
